// File: src/ats_pkg.sv
package ats_pkg;

  localparam int MAX_TERMS_DEF = 1024;
  localparam int X_ONE = 16384;
  localparam int MUL_SHIFT = 28;
  localparam int POW_W = 32;
  localparam int MULT_W = 30;
  localparam int MAG_W = 31;
  localparam int SUM_W = 32;

  typedef logic [2:0] upc_t;

  localparam upc_t S_IDLE     = 3'd0;
  localparam upc_t S_MULX     = 3'd1;
  localparam upc_t S_TEST     = 3'd2;
  localparam upc_t S_DIV_INIT = 3'd3;
  localparam upc_t S_DIV_STEP = 3'd4;
  localparam upc_t S_ACCUM    = 3'd5;
  localparam upc_t S_POWER    = 3'd6;
  localparam upc_t S_DONE     = 3'd7;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_ZERO_COUNT,
    JC_DIV_BUSY,
    JC_OUT_FULL
  } jcond_t;

  typedef struct packed {
    logic   take;
    logic   mulx;
    logic   div_init;
    logic   div_step;
    logic   accum;
    logic   pow_upd;
    logic   out_load;
    jcond_t cond;
    upc_t   target;
  } ucode_t;

  // control store, one word per step
  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    w = '{take: 1'b0, mulx: 1'b0, div_init: 1'b0, div_step: 1'b0, accum: 1'b0,
          pow_upd: 1'b0, out_load: 1'b0, cond: JC_NEXT, target: S_IDLE};
    case (addr)
      S_IDLE: begin
        w.take = 1'b1;
        w.cond = JC_NO_INPUT;
        w.target = S_IDLE;
      end
      S_MULX: begin
        w.mulx = 1'b1;
      end
      S_TEST: begin
        w.cond = JC_ZERO_COUNT;
        w.target = S_DONE;
      end
      S_DIV_INIT: begin
        w.div_init = 1'b1;
      end
      S_DIV_STEP: begin
        w.div_step = 1'b1;
        w.cond = JC_DIV_BUSY;
        w.target = S_DIV_STEP;
      end
      S_ACCUM: begin
        w.accum = 1'b1;
      end
      S_POWER: begin
        w.pow_upd = 1'b1;
        w.cond = JC_ALWAYS;
        w.target = S_TEST;
      end
      S_DONE: begin
        w.out_load = 1'b1;
        w.cond = JC_OUT_FULL;
        w.target = S_DONE;
      end
      default: begin
        w.cond = JC_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/arctan_series_sum.sv
// Partial Maclaurin sum of arctan(x): a word carries x in signed Q2.14 (clamped to
// -1..+1) and a term count n (clamped to MAX_TERMS); the result word is the sum of
// the first n series terms in signed Q2.30, zero for n = 0. One word is worked on
// at a time, and the input opens in the cycle after the result register is loaded.
// Each term passes through the divider load, a restoring divider shared over all
// terms, the accumulate, the running-power multiply and the loop test. A finished
// result waits in an output register, so the next word can be taken while it is
// still stalled.
module arctan_series_sum #(
  parameter int MAX_TERMS = ats_pkg::MAX_TERMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_value,
  input  logic        [10:0] term_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] arctan_value
);
  import ats_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int DW = $clog2(2 * MAX_TERMS);
  localparam int BW = $clog2(MAG_W);
  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(64'sd1 <<< 30);
  localparam logic signed [SUM_W:0] SUM_MIN = -SUM_MAX;

  upc_t   step;
  upc_t   step_next;
  ucode_t cw;

  logic signed [15:0]         xs;
  logic signed [POW_W-1:0]    power;
  logic signed [MULT_W-1:0]   mult;
  logic signed [SUM_W-1:0]    sum;
  logic        [CW-1:0]       count;
  logic        [DW-1:0]       denom;
  logic        [DW-1:0]       rem;
  logic        [MAG_W-1:0]    dq;
  logic        [BW-1:0]       div_cnt;
  logic                       neg;

  logic signed [15:0]         x_sat;
  logic signed [POW_W-1:0]    mul_a;
  logic signed [MULT_W-1:0]   mul_b;
  logic signed [POW_W+MULT_W-1:0] prod;
  logic signed [POW_W+MULT_W-1:0] prod_sh;
  logic        [DW:0]         rem_sh;
  logic        [DW:0]         rem_sub;
  logic                       qbit;
  logic signed [SUM_W-1:0]    quot;
  logic signed [SUM_W:0]      sum_add;
  logic        [POW_W-1:0]    power_abs;
  logic                       accept;
  logic                       out_full;
  logic                       jump;

  assign cw       = ucode_rom(step);
  assign in_stall = !cw.take;
  assign accept   = in_valid && cw.take;
  assign out_full = out_valid && out_stall;

  // clamp argument
  always_comb begin
    x_sat = x_value;
    if (x_value > 16'(X_ONE)) begin
      x_sat = 16'(X_ONE);
    end else if (x_value < -16'(X_ONE)) begin
      x_sat = -16'(X_ONE);
    end
  end

  // shared multiplier
  assign mul_a   = cw.mulx ? POW_W'(xs) : power;
  assign mul_b   = cw.mulx ? MULT_W'(xs) : mult;
  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> MUL_SHIFT;

  // restoring divider step
  assign rem_sh  = {rem, dq[MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, denom};
  assign qbit    = (rem_sh >= {1'b0, denom});

  assign power_abs = power[POW_W-1] ? -power : power;
  assign quot      = neg ? -SUM_W'(dq) : SUM_W'(dq);
  assign sum_add   = (SUM_W + 1)'(sum) + (SUM_W + 1)'(quot);

  // sequencer
  always_comb begin
    case (cw.cond)
      JC_NEXT:       jump = 1'b0;
      JC_ALWAYS:     jump = 1'b1;
      JC_NO_INPUT:   jump = !in_valid;
      JC_ZERO_COUNT: jump = (count == '0);
      JC_DIV_BUSY:   jump = (div_cnt != '0);
      JC_OUT_FULL:   jump = out_full;
      default:       jump = 1'b1;
    endcase
    step_next = jump ? cw.target : step + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (cw.out_load && !out_full) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xs    <= x_sat;
      power <= {x_sat, 16'b0};
      sum   <= '0;
      denom <= DW'(1);
      if (int'(term_count) > MAX_TERMS) begin
        count <= CW'(MAX_TERMS);
      end else begin
        count <= CW'(term_count);
      end
    end
    if (cw.mulx) begin
      mult <= -prod[MULT_W-1:0];
    end
    if (cw.div_init) begin
      rem     <= '0;
      dq      <= power_abs[MAG_W-1:0];
      neg     <= power[POW_W-1];
      div_cnt <= BW'(MAG_W - 1);
    end
    if (cw.div_step) begin
      rem     <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      dq      <= {dq[MAG_W-2:0], qbit};
      div_cnt <= div_cnt - BW'(1);
    end
    if (cw.accum) begin
      if (sum_add > SUM_MAX) begin
        sum <= SUM_W'(SUM_MAX);
      end else if (sum_add < SUM_MIN) begin
        sum <= SUM_W'(SUM_MIN);
      end else begin
        sum <= sum_add[SUM_W-1:0];
      end
      denom <= denom + DW'(2);
      count <= count - CW'(1);
    end
    if (cw.pow_upd) begin
      power <= prod_sh[POW_W-1:0];
    end
    if (cw.out_load && !out_full) begin
      arctan_value <= sum;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (step == S_MULX))
    else $error("accepted word did not start the program");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (step == S_DIV_STEP && div_cnt == '0) |=> (step == S_ACCUM))
    else $error("divider did not finish after its last step");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (step == S_TEST) |-> (SUM_W + 1)'(sum) <= SUM_MAX && (SUM_W + 1)'(sum) >= SUM_MIN)
    else $error("running sum out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(step) == S_DONE))
    else $error("result word raised outside the done step");
`endif

endmodule

// File: sim/arctan_series_sum_tb.sv
module arctan_series_sum_tb;

  localparam int QUIET_LIMIT = 160000;
  localparam int HOLD_CYCLES = 400;
  localparam longint SUM_LIM = 64'sd1073741824;

  typedef struct packed {
    logic signed [15:0] x;
    logic        [10:0] n;
    logic               known;
    logic signed [31:0] res;
  } dir_row_t;

  localparam int DIR_ROWS = 18;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{16'sd0,      11'd0,    1'b1, 32'sd0},
    '{16'sd16384,  11'd0,    1'b1, 32'sd0},
    '{16'sd16384,  11'd1,    1'b1, 32'sd1073741824},
    '{-16'sd16384, 11'd1,    1'b1, -32'sd1073741824},
    '{16'sd0,      11'd5,    1'b1, 32'sd0},
    '{16'sd32767,  11'd1,    1'b1, 32'sd1073741824},
    '{-16'sd32768, 11'd1,    1'b1, -32'sd1073741824},
    '{16'sd16384,  11'd1024, 1'b0, 32'sd0},
    '{-16'sd16384, 11'd2047, 1'b0, 32'sd0},
    '{16'sd32767,  11'd20,   1'b0, 32'sd0},
    '{-16'sd32768, 11'd20,   1'b0, 32'sd0},
    '{16'sd8192,   11'd10,   1'b0, 32'sd0},
    '{-16'sd8192,  11'd10,   1'b0, 32'sd0},
    '{16'sd1,      11'd3,    1'b0, 32'sd0},
    '{-16'sd1,     11'd3,    1'b0, 32'sd0},
    '{16'sd16383,  11'd50,   1'b0, 32'sd0},
    '{-16'sd16383, 11'd50,   1'b0, 32'sd0},
    '{16'sd12345,  11'd1025, 1'b0, 32'sd0}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] x_value;
  logic        [10:0] term_count;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] arctan_value;

  logic signed [31:0] pending_arctan [$];
  logic signed [31:0] want;
  logic               cur_known;
  logic signed [31:0] cur_res;
  logic               hold_req;
  logic               accepted;
  int                 quiet_cycles;
  int                 mismatch_cnt;
  int                 burst_left;

  arctan_series_sum u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_value      (x_value),
    .term_count   (term_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .arctan_value (arctan_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp x and n, then sum the alternating odd-power series term by term
  function automatic logic signed [31:0] arctan_sum(logic signed [15:0] x_in,
                                                    logic [10:0] n_in);
    longint xs;
    longint pw;
    longint mul;
    longint acc;
    longint den;
    int     terms;
    xs = x_in;
    if (xs > ats_pkg::X_ONE) xs = ats_pkg::X_ONE;
    if (xs < -ats_pkg::X_ONE) xs = -ats_pkg::X_ONE;
    terms = (n_in > ats_pkg::MAX_TERMS_DEF) ? ats_pkg::MAX_TERMS_DEF : int'(n_in);
    pw = xs * 65536;
    mul = -(xs * xs);
    acc = 0;
    den = 1;
    for (int k = 0; k < terms; k++) begin
      acc += pw / den;
      if (acc > SUM_LIM) acc = SUM_LIM;
      if (acc < -SUM_LIM) acc = -SUM_LIM;
      pw = (pw * mul) >>> ats_pkg::MUL_SHIFT;
      den += 2;
    end
    return acc[31:0];
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(logic signed [15:0] x, logic [10:0] n, logic known,
                           logic signed [31:0] res, bit paced);
    int gap;
    if (paced && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid = 1'b1;
    x_value = x;
    term_count = n;
    cur_known = known;
    cur_res = res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_arctan.size() != 0) @(negedge clk);
  endtask

  task automatic random_word();
    logic signed [15:0] x;
    logic        [10:0] n;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 10) x = 16'($urandom_range(0, 65535));
    else x = 16'($urandom_range(0, 32768) - 16384);
    r = $urandom_range(0, 99);
    if (r < 5) n = '0;
    else if (r < 85) n = 11'($urandom_range(1, 24));
    else if (r < 97) n = 11'($urandom_range(25, 300));
    else n = 11'($urandom_range(301, 2047));
    send_word(x, n, 1'b0, 32'sd0, 1'b1);
  endtask

  // output side: check results, record accepted inputs, track quiet cycles
  always @(posedge clk) begin
    if (!rst) begin
      accepted = 1'b0;
      if (out_valid && !out_stall) begin
        accepted = 1'b1;
        if (pending_arctan.size() == 0) begin
          $error("arctan_value: expected none, actual %0d", arctan_value);
          mismatch_cnt++;
        end else begin
          want = pending_arctan.pop_front();
          if (arctan_value !== want) begin
            $error("arctan_value: expected %0d, actual %0d", want, arctan_value);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        accepted = 1'b1;
        pending_arctan.push_back(cur_known ? cur_res : arctan_sum(x_value, term_count));
      end
      quiet_cycles = accepted ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        int mode;
        int len;
        mode = $urandom_range(0, 2);
        len = $urandom_range(5, 60);
        for (int c = 0; c < len; c++) begin
          if (hold_req) break;
          case (mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 3) == 0);
            default: out_stall = ($urandom_range(0, 3) != 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    x_value = '0;
    term_count = '0;
    cur_known = 1'b0;
    cur_res = '0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    mismatch_cnt = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(DIR_TABLE[i].x, DIR_TABLE[i].n, DIR_TABLE[i].known, DIR_TABLE[i].res, 1'b1);
    drain();

    // receiver holds off while short words keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_word(16'($urandom_range(0, 32768) - 16384), 11'($urandom_range(1, 2)),
                1'b0, 32'sd0, 1'b0);
    drain();

    for (int i = 0; i < 100; i++) begin
      random_word();
      if (i == 50) drain();
    end
    drain();
    repeat (50) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
